### rtl/sequence_replay_window_check_assert.svh
// assertion macros for the replay window check
`ifndef SEQUENCE_REPLAY_WINDOW_CHECK_ASSERT_SVH
`define SEQUENCE_REPLAY_WINDOW_CHECK_ASSERT_SVH

// same-cycle implication on clk, idle while rst is high
`define SRWC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("replay window check assertion failed");

// next-cycle implication on clk, idle while rst is high
`define SRWC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("replay window check assertion failed");

`endif

### rtl/srwc_pkg.sv
// package for the replay window check: widths, reset value, step type
`timescale 1ns / 1ps
package srwc_pkg;

  localparam int SEQ_W        = 32;
  localparam int BIAS_W       = 6;
  localparam int BITMAP_WIDTH = 64;
  localparam int BM_IDX_W     = $clog2(BITMAP_WIDTH);
  localparam int SHIFT_W      = 6;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 8;

  localparam logic [BIAS_W-1:0] BIAS_RESET = BIAS_W'(60);

  typedef struct packed {
    logic                    ok;
    logic [SEQ_W-1:0]        low_expected;
    logic [SEQ_W-1:0]        high_next;
    logic [BITMAP_WIDTH-1:0] seen_bitmap;
  } step_t;

endpackage

### rtl/sequence_replay_window_check.sv
// sliding window anti-replay check, one sequence number per word
`timescale 1ns / 1ps
// a word held in the input register is registered as a result once the output has room
// throughput: one word per cycle, sustained, with both sides streaming
// the window state is read and updated in the single stage between input and output registers
// reset clears low_expected, high_next and the bitmap, and sets max_bias to 60
// no clearing pass: the block accepts words as soon as rst is released
`include "sequence_replay_window_check_assert.svh"

module sequence_replay_window_check (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [srwc_pkg::BIAS_W-1:0]         cfg_wdata,    // max_bias
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [srwc_pkg::IN_TDATA_W-1:0]     s_tdata,      // [31:0] recv_seq
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [srwc_pkg::OUT_TDATA_W-1:0]    m_tdata       // [0] accepted, rest zero
);

  localparam int SW = srwc_pkg::SEQ_W;
  localparam int BW = srwc_pkg::BITMAP_WIDTH;

  logic [srwc_pkg::BIAS_W-1:0] max_bias;
  logic                        in_valid;
  logic [SW-1:0]               in_seq;
  logic                        accepted;
  logic [SW-1:0]               low_expected;
  logic [SW-1:0]               high_next;
  logic [BW-1:0]               seen_bitmap;
  logic                        advance;
  srwc_pkg::step_t             cur;
  srwc_pkg::step_t             step_next;

  function automatic logic is_neg(input logic [SW-1:0] a);
    return a[SW-1];
  endfunction

  function automatic logic slt(input logic [SW-1:0] a, input logic [SW-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic srwc_pkg::step_t reject(input srwc_pkg::step_t st);
    srwc_pkg::step_t res;
    res = st;
    res.ok = 1'b0;
    return res;
  endfunction

  // duplicate test on bit (high_next - r)
  function automatic srwc_pkg::step_t dup_check(input srwc_pkg::step_t st,
                                                input logic [SW-1:0] r);
    srwc_pkg::step_t res;
    logic [SW-1:0]   off;
    logic            in_win;
    res = st;
    off = st.high_next - r;
    in_win = off < SW'(BW);
    res.ok = 1'b1;
    if (in_win) begin
      if (st.seen_bitmap[off[srwc_pkg::BM_IDX_W-1:0]]) begin
        res.ok = 1'b0;
      end else begin
        res.seen_bitmap[off[srwc_pkg::BM_IDX_W-1:0]] = 1'b1;
      end
    end
    return res;
  endfunction

  // window advance, limited by max_bias from low_expected
  function automatic srwc_pkg::step_t over_max(input srwc_pkg::step_t st,
                                               input logic [SW-1:0] r,
                                               input logic [srwc_pkg::BIAS_W-1:0] bias);
    srwc_pkg::step_t res;
    logic [SW-1:0]   diff;
    logic [SW-1:0]   ahead;
    logic [SW-1:0]   shift;
    res = st;
    res.ok = 1'b0;
    diff  = r - st.high_next;
    ahead = r - st.low_expected;
    shift = diff + SW'(1);
    if (!diff[SW-1] && slt(ahead, SW'(bias))) begin
      res.ok = 1'b1;
      res.high_next = r + SW'(1);
      if (shift < SW'(64)) begin
        res.seen_bitmap = st.seen_bitmap << shift[srwc_pkg::SHIFT_W-1:0];
      end else begin
        res.seen_bitmap = '0;
      end
      res.seen_bitmap[1] = 1'b1;
    end
    return res;
  endfunction

  function automatic srwc_pkg::step_t all_range(input srwc_pkg::step_t st,
                                                input logic [SW-1:0] r,
                                                input logic [srwc_pkg::BIAS_W-1:0] bias);
    srwc_pkg::step_t res;
    res = reject(st);
    if (r == st.low_expected) begin
      res.ok = 1'b1;
      res.low_expected = r + SW'(1);
    end else if (slt(st.low_expected, r)) begin
      if (slt(r, st.high_next)) begin
        res = dup_check(st, r);
      end else begin
        res = over_max(st, r, bias);
      end
    end
    return res;
  endfunction

  function automatic srwc_pkg::step_t low_side(input srwc_pkg::step_t st,
                                               input logic [SW-1:0] r);
    srwc_pkg::step_t res;
    res = reject(st);
    if (r == st.low_expected) begin
      res.ok = 1'b1;
      res.low_expected = r + SW'(1);
    end else if (slt(st.low_expected, r)) begin
      res = dup_check(st, r);
    end
    return res;
  endfunction

  function automatic srwc_pkg::step_t high_side(input srwc_pkg::step_t st,
                                                input logic [SW-1:0] r,
                                                input logic [srwc_pkg::BIAS_W-1:0] bias);
    srwc_pkg::step_t res;
    if (slt(r, st.high_next)) begin
      res = dup_check(st, r);
    end else begin
      res = over_max(st, r, bias);
    end
    return res;
  endfunction

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tdata  = {{(srwc_pkg::OUT_TDATA_W-1){1'b0}}, accepted};

  assign cur.ok           = 1'b0;
  assign cur.low_expected = low_expected;
  assign cur.high_next    = high_next;
  assign cur.seen_bitmap  = seen_bitmap;

  // dispatch on the order and signs of low_expected and high_next
  always_comb begin
    logic ds;
    ds = is_neg(low_expected) != is_neg(high_next);
    step_next = reject(cur);
    if (low_expected == high_next) begin
      if (in_seq == low_expected) begin
        step_next.ok = 1'b1;
        step_next.low_expected = in_seq + SW'(1);
        step_next.high_next = in_seq + SW'(1);
      end else if (is_neg(in_seq) == is_neg(low_expected)) begin
        if (slt(high_next, in_seq)) begin
          step_next = over_max(cur, in_seq, max_bias);
        end
      end else begin
        step_next = over_max(cur, in_seq, max_bias);
      end
    end else if (slt(low_expected, high_next) && !ds) begin
      if (!is_neg(low_expected)) begin
        if (!is_neg(in_seq)) begin
          step_next = all_range(cur, in_seq, max_bias);
        end else begin
          step_next = over_max(cur, in_seq, max_bias);
        end
      end else if (is_neg(high_next)) begin
        if (is_neg(in_seq)) begin
          step_next = all_range(cur, in_seq, max_bias);
        end else begin
          step_next = over_max(cur, in_seq, max_bias);
        end
      end
    end else if (slt(high_next, low_expected) && ds) begin
      if (!is_neg(in_seq)) begin
        step_next = low_side(cur, in_seq);
      end else begin
        step_next = high_side(cur, in_seq, max_bias);
      end
    end else if (slt(low_expected, high_next) && ds) begin
      if (!is_neg(in_seq)) begin
        step_next = high_side(cur, in_seq, max_bias);
      end else begin
        step_next = low_side(cur, in_seq);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bias <= srwc_pkg::BIAS_RESET;
    end else if (cfg_we) begin
      max_bias <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_seq <= s_tdata[SW-1:0];
    end
  end

  // window state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      low_expected <= '0;
      high_next    <= '0;
      seen_bitmap  <= '0;
      m_tvalid     <= 1'b0;
    end else if (advance) begin
      low_expected <= step_next.low_expected;
      high_next    <= step_next.high_next;
      seen_bitmap  <= step_next.seen_bitmap;
      m_tvalid     <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      accepted <= step_next.ok;
    end
  end

  // bit 0 stands for high_next itself, which is never a seen sequence
  `SRWC_ASSERT_NOW(a_bit0_clear, 1'b1, !seen_bitmap[0])
  `SRWC_ASSERT_NEXT(a_idle_state_holds, !advance,
    $stable(low_expected) && $stable(high_next) && $stable(seen_bitmap))
  `SRWC_ASSERT_NEXT(a_reject_state_holds, advance && !step_next.ok,
    $stable(low_expected) && $stable(high_next) && $stable(seen_bitmap))
  `SRWC_ASSERT_NOW(a_result_from_input, $rose(m_tvalid), $past(in_valid))

endmodule
